@@ rtl/fmpf_pkg.sv @@
// Package for the first-match packet filter.
// Holds command, status, protocol and sequencer state codes, the chain depth and the rule record type.
// No dependencies.
package fmpf_pkg;

  localparam int unsigned RulesPerChain = 16;

  typedef enum logic [1:0] {
    KIND_INSERT   = 2'd0,
    KIND_DELETE   = 2'd1,
    KIND_FLUSH    = 2'd2,
    KIND_CLASSIFY = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_CHAIN = 2'd1,
    STAT_FULL      = 2'd2,
    STAT_NOT_FOUND = 2'd3
  } status_t;

  localparam logic [7:0] ProtoAny = 8'd0;
  localparam logic [7:0] ProtoTcp = 8'd6;
  localparam logic [7:0] ProtoUdp = 8'd17;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_DONE
  } state_t;

  // one rule as held in the rule memory
  typedef struct packed {
    logic [31:0] src_net;
    logic [31:0] src_mask;
    logic [31:0] dst_net;
    logic [31:0] dst_mask;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [7:0]  proto;
    logic        action;
  } rule_t;

endpackage

@@ rtl/first_match_packet_filter_top.sv @@
// First-match packet filter: top level with rule memory and walk sequencer.
// Depends on fmpf_pkg.
//
// Usage:
//   Commands enter on the s_axis channel (tvalid/tready/tdata) and one
//   result per command leaves on m_axis. tuser carries kind, chain and
//   action; tdata carries the rule or packet fields.
//   Insert appends a rule to a chain, delete removes the newest equal rule,
//   flush empties both chains, classify walks a chain newest to oldest and
//   returns the first matching rule's verdict (accept if none matches).
//   Steps: flush, an invalid chain and insert finish in the decide step;
//   classify then checks one rule per visit; delete walks like classify
//   and then moves every newer rule down one slot, a read and a write
//   per rule. All cases are set by the single-port rule memory, read one
//   rule per access, and the one shared compare unit.
//   One command is in flight at a time; s_axis_tready is low from accept
//   until its result is taken. A stalled m_axis holds its result and the
//   block waits.
//   Reset clears both chain counts; the memory needs no clearing pass.
module first_match_packet_filter_top #(
  parameter int unsigned RULES_PER_CHAIN = fmpf_pkg::RulesPerChain
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: src_net[31:0], src_mask[63:32], dst_net[95:64], dst_mask[127:96],
  //        src_port[143:128], dst_port[159:144], proto[167:160]
  input  logic [167:0] s_axis_tdata,
  // tuser: kind[1:0], chain[3:2], action[4]
  input  logic [4:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: status[1:0], verdict[2], rule_count[7:3]
  output logic [7:0]   m_axis_tdata
);

  localparam int unsigned IdxW  = (RULES_PER_CHAIN > 1) ? $clog2(RULES_PER_CHAIN) : 1;
  localparam int unsigned CntW  = $clog2(RULES_PER_CHAIN + 1);
  localparam int unsigned SlotW = IdxW + 1;
  localparam int unsigned Slots = 2 * RULES_PER_CHAIN;

  fmpf_pkg::state_t state, state_next;

  // command registers
  fmpf_pkg::rule_t cmd;
  logic [1:0] cmd_kind;
  logic       cmd_chain;
  logic [CntW-1:0] cnt_in, cnt_out;
  logic [CntW-1:0] cur_cnt;
  logic [CntW-1:0] ptr;          // walk position: rule index + 1
  logic [1:0]      res_status;
  logic            res_verdict;
  logic [CntW-1:0] res_count;

  // rule memory, both chains, one port
  fmpf_pkg::rule_t mem [Slots];
  fmpf_pkg::rule_t rd;
  logic            mem_we;
  logic [SlotW-1:0] mem_addr;
  fmpf_pkg::rule_t mem_wd;

  logic accept_in;
  assign accept_in = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == fmpf_pkg::ST_IDLE);
  assign m_axis_tvalid = (state == fmpf_pkg::ST_DONE);
  assign m_axis_tdata = {5'(res_count), res_verdict, res_status};

  assign cur_cnt = cmd_chain ? cnt_out : cnt_in;

  function automatic logic [SlotW-1:0] slot_of(logic ch, logic [CntW-1:0] idx);
    logic [SlotW-1:0] base;
    base = ch ? SlotW'(RULES_PER_CHAIN) : '0;
    return base + SlotW'(idx);
  endfunction

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_addr] <= mem_wd;
    end
    rd <= mem[mem_addr];
  end

  // shared compare unit: packet match and exact rule match
  logic hit_pkt, hit_eq, port_ok;
  always_comb begin
    port_ok = (rd.src_port == '0 || rd.src_port == cmd.src_port) &&
              (rd.dst_port == '0 || rd.dst_port == cmd.dst_port);
    hit_pkt = (rd.src_net == '0 || (cmd.src_net & rd.src_mask) == rd.src_net) &&
              (rd.dst_net == '0 || (cmd.dst_net & rd.dst_mask) == rd.dst_net) &&
              (rd.proto == fmpf_pkg::ProtoAny ||
               (cmd.proto == rd.proto &&
                ((cmd.proto != fmpf_pkg::ProtoTcp && cmd.proto != fmpf_pkg::ProtoUdp)
                 || port_ok)));
    hit_eq  = rd.src_net == cmd.src_net && rd.src_mask == cmd.src_mask &&
              rd.dst_net == cmd.dst_net && rd.dst_mask == cmd.dst_mask &&
              rd.src_port == cmd.src_port && rd.dst_port == cmd.dst_port &&
              rd.proto == cmd.proto;
  end

  // next state, memory access
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_addr   = slot_of(cmd_chain, ptr - CntW'(1));
    mem_wd     = rd;
    unique case (state)
      fmpf_pkg::ST_IDLE: begin
        if (accept_in) begin
          state_next = fmpf_pkg::ST_READ;
        end
      end
      fmpf_pkg::ST_READ: begin
        // decide; start a walk or finish at once
        priority if (cmd_kind == fmpf_pkg::KIND_FLUSH) begin
          state_next = fmpf_pkg::ST_DONE;
        end else if (res_status == fmpf_pkg::STAT_BAD_CHAIN) begin
          state_next = fmpf_pkg::ST_DONE;
        end else if (cmd_kind == fmpf_pkg::KIND_INSERT) begin
          state_next = fmpf_pkg::ST_DONE;
          if (cur_cnt < CntW'(RULES_PER_CHAIN)) begin
            mem_we   = 1'b1;
            mem_addr = slot_of(cmd_chain, cur_cnt);
            mem_wd   = cmd;
          end
        end else if (ptr == '0) begin
          state_next = fmpf_pkg::ST_DONE;
        end else begin
          state_next = fmpf_pkg::ST_CHECK;
        end
      end
      fmpf_pkg::ST_CHECK: begin
        priority if (cmd_kind == fmpf_pkg::KIND_CLASSIFY && hit_pkt) begin
          state_next = fmpf_pkg::ST_DONE;
        end else if (cmd_kind == fmpf_pkg::KIND_DELETE && hit_eq) begin
          state_next = fmpf_pkg::ST_SHIFT_RD;
          mem_addr   = slot_of(cmd_chain, ptr);
        end else if (ptr == CntW'(1)) begin
          state_next = fmpf_pkg::ST_DONE;
        end else begin
          mem_addr   = slot_of(cmd_chain, ptr - CntW'(2));
        end
      end
      fmpf_pkg::ST_SHIFT_RD: begin
        // rd holds rule ptr; write it to slot ptr-1
        if (ptr >= cur_cnt) begin
          state_next = fmpf_pkg::ST_DONE;
        end else begin
          state_next = fmpf_pkg::ST_SHIFT_WR;
          mem_we     = 1'b1;
          mem_addr   = slot_of(cmd_chain, ptr - CntW'(1));
        end
      end
      fmpf_pkg::ST_SHIFT_WR: begin
        // fetch the next newer rule
        state_next = fmpf_pkg::ST_SHIFT_RD;
        mem_addr   = slot_of(cmd_chain, ptr + CntW'(1));
      end
      fmpf_pkg::ST_DONE: begin
        if (m_axis_tready) begin
          state_next = fmpf_pkg::ST_IDLE;
        end
      end
      default: state_next = fmpf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= fmpf_pkg::ST_IDLE;
      cnt_in  <= '0;
      cnt_out <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        fmpf_pkg::ST_READ: begin
          if (cmd_kind == fmpf_pkg::KIND_FLUSH) begin
            cnt_in  <= '0;
            cnt_out <= '0;
          end else if (res_status != fmpf_pkg::STAT_BAD_CHAIN &&
                       cmd_kind == fmpf_pkg::KIND_INSERT &&
                       cur_cnt < CntW'(RULES_PER_CHAIN)) begin
            if (cmd_chain) cnt_out <= cnt_out + CntW'(1);
            else           cnt_in  <= cnt_in + CntW'(1);
          end
        end
        fmpf_pkg::ST_SHIFT_RD: begin
          if (ptr >= cur_cnt) begin
            if (cmd_chain) cnt_out <= cnt_out - CntW'(1);
            else           cnt_in  <= cnt_in - CntW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // command capture, walk pointer and result
  always_ff @(posedge clk) begin
    unique case (state)
      fmpf_pkg::ST_IDLE: begin
        if (accept_in) begin
          cmd.src_net  <= s_axis_tdata[31:0];
          cmd.src_mask <= s_axis_tdata[63:32];
          cmd.dst_net  <= s_axis_tdata[95:64];
          cmd.dst_mask <= s_axis_tdata[127:96];
          cmd.src_port <= s_axis_tdata[143:128];
          cmd.dst_port <= s_axis_tdata[159:144];
          cmd.proto    <= s_axis_tdata[167:160];
          cmd.action   <= s_axis_tuser[4];
          cmd_kind     <= s_axis_tuser[1:0];
          cmd_chain    <= s_axis_tuser[2];
          res_verdict  <= 1'b0;
          res_status   <= (s_axis_tuser[1:0] != fmpf_pkg::KIND_FLUSH && s_axis_tuser[3])
                          ? fmpf_pkg::STAT_BAD_CHAIN : fmpf_pkg::STAT_OK;
          ptr          <= s_axis_tuser[2] ? cnt_out : cnt_in;
        end
      end
      fmpf_pkg::ST_READ: begin
        priority if (cmd_kind == fmpf_pkg::KIND_FLUSH ||
                     res_status == fmpf_pkg::STAT_BAD_CHAIN) begin
          res_count <= '0;
        end else if (cmd_kind == fmpf_pkg::KIND_INSERT) begin
          if (cur_cnt < CntW'(RULES_PER_CHAIN)) begin
            res_count <= cur_cnt + CntW'(1);
          end else begin
            res_count  <= cur_cnt;
            res_status <= fmpf_pkg::STAT_FULL;
          end
        end else begin
          res_count <= cur_cnt;
          if (ptr == '0 && cmd_kind == fmpf_pkg::KIND_DELETE) begin
            res_status <= fmpf_pkg::STAT_NOT_FOUND;
          end
        end
      end
      fmpf_pkg::ST_CHECK: begin
        priority if (cmd_kind == fmpf_pkg::KIND_CLASSIFY && hit_pkt) begin
          res_verdict <= rd.action;
        end else if (cmd_kind == fmpf_pkg::KIND_DELETE && hit_eq) begin
          res_count <= cur_cnt - CntW'(1);
        end else if (ptr == CntW'(1)) begin
          if (cmd_kind == fmpf_pkg::KIND_DELETE) begin
            res_status <= fmpf_pkg::STAT_NOT_FOUND;
          end
        end else begin
          ptr <= ptr - CntW'(1);
        end
      end
      fmpf_pkg::ST_SHIFT_RD: ;
      fmpf_pkg::ST_SHIFT_WR: begin
        ptr <= ptr + CntW'(1);
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  // chain counts never exceed capacity
  assert property (@(posedge clk) disable iff (rst)
    cnt_in <= CntW'(RULES_PER_CHAIN) && cnt_out <= CntW'(RULES_PER_CHAIN))
    else $error("chain count above capacity");
  // no new command while a result is pending
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("input ready during result");
  // a result that is stalled holds its value
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("stalled result changed");
  // verdict is zero for anything but classify
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && cmd_kind != fmpf_pkg::KIND_CLASSIFY |-> !m_axis_tdata[2])
    else $error("verdict set on non-classify");
`endif

endmodule
